FILE: rtl/core/sbcf_pkg.sv
// Shared types and constants for the serial bus servo command framer.
// No dependencies; every other file of the block imports this package.
package sbcf_pkg;

  localparam logic [7:0]  HDR_BYTE        = 8'h55;
  localparam logic [7:0]  OP_MOVE         = 8'h01;
  localparam logic [7:0]  OP_TORQUE       = 8'h1F;
  localparam logic [7:0]  LEN_MOVE        = 8'd7;
  localparam logic [7:0]  LEN_TORQUE      = 8'd4;
  localparam logic [7:0]  TORQUE_PARAM    = 8'h01;
  localparam logic [15:0] MOVE_TIME_RESET = 16'd100;

  // Mode codes carried on the input tuser bit.
  localparam logic MODE_MOVE   = 1'b0;
  localparam logic MODE_TORQUE = 1'b1;

  // Angle limit in 1/16 degree (240 degrees) and the reciprocal of 3 in Q17.
  localparam logic [11:0] ANGLE_MAX_Q4 = 12'd3840;
  localparam logic [15:0] RECIP3_Q17   = 16'd43691;

  localparam int POS_W = 10;
  localparam int IDX_W = 4;

  // Byte positions inside a frame.
  localparam logic [IDX_W-1:0] BYTE_HDR0 = 4'd0;
  localparam logic [IDX_W-1:0] BYTE_HDR1 = 4'd1;
  localparam logic [IDX_W-1:0] BYTE_ID   = 4'd2;
  localparam logic [IDX_W-1:0] BYTE_LEN  = 4'd3;
  localparam logic [IDX_W-1:0] BYTE_OP   = 4'd4;
  localparam logic [IDX_W-1:0] BYTE_P0   = 4'd5;
  localparam logic [IDX_W-1:0] BYTE_P1   = 4'd6;
  localparam logic [IDX_W-1:0] BYTE_P2   = 4'd7;
  localparam logic [IDX_W-1:0] BYTE_P3   = 4'd8;
  localparam logic [IDX_W-1:0] BYTE_CKS  = 4'd9;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified command as it waits between front and back.
  typedef struct packed {
    logic               torque;
    logic [7:0]         id;
    logic [POS_W-1:0]   pos;
  } cmd_t;

endpackage

FILE: rtl/core/sbcf_front.sv
// Front end of the framer: accepts commands, decodes the mode and scales the angle.
// Depends on sbcf_pkg; feeds sbcf_cmd_fifo.
module sbcf_front
  import sbcf_pkg::*;
(
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] servo_id, [23:8] angle_q4
  input  logic        in_tuser,   // mode
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_wdata
);

  logic signed [15:0] angle_q4;
  logic [11:0]        angle_clamped;
  logic [16:0]        scaled;
  logic [11:0]        div32;
  logic [27:0]        prod;

  assign angle_q4 = in_tdata[23:8];

  always_comb begin
    if (angle_q4[15]) begin
      angle_clamped = '0;
    end else if (angle_q4 > $signed({4'b0, ANGLE_MAX_Q4})) begin
      angle_clamped = ANGLE_MAX_Q4;
    end else begin
      angle_clamped = angle_q4[11:0];
    end
  end

  // pos = floor(a * 25 / 96) = floor(floor(a * 25 / 32) / 3).
  assign scaled = ({5'b0, angle_clamped} << 4) + ({5'b0, angle_clamped} << 3)
                + {5'b0, angle_clamped};
  assign div32  = scaled[16:5];
  assign prod   = {16'b0, div32} * {12'b0, RECIP3_Q17};

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_wdata.torque = (in_tuser == MODE_TORQUE);
  assign q_wdata.id     = in_tdata[7:0];
  assign q_wdata.pos    = prod[17 +: POS_W];

endmodule

FILE: rtl/core/sbcf_cmd_fifo.sv
// Short command queue that decouples the front end from the byte sequencer.
// Depends on sbcf_pkg for cmd_t and the queue depth.
module sbcf_cmd_fifo
  import sbcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t rdata
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/sbcf_back.sv
// Back end of the framer: walks a queued command through its frame one byte per cycle while the receiver takes bytes.
// Depends on sbcf_pkg; takes commands from sbcf_cmd_fifo and drives the output register.
module sbcf_back
  import sbcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] move_time_ms,
  input  logic        q_not_empty,
  input  cmd_t        q_rdata,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // tx_byte
  output logic        out_tlast    // last_byte
);

  cmd_t             cur_r;
  logic [7:0]       cks_r, cks_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  logic             advance;
  logic             is_last;
  logic             load;
  logic [7:0]       cur_byte;
  logic [7:0]       pos_lo;
  logic [7:0]       pos_hi;

  assign pos_lo = cur_r.pos[7:0];
  assign pos_hi = {{(16 - POS_W){1'b0}}, cur_r.pos[POS_W-1:8]};

  assign is_last = cur_r.torque ? (idx_r == BYTE_P1) : (idx_r == BYTE_CKS);
  assign advance = busy_r && (!out_valid_r || out_tready);
  // The next command is picked up on the same cycle the checksum byte enters the output register.
  assign load    = q_not_empty && (!busy_r || (advance && is_last));
  assign q_pop   = load;

  // Checksum of the queued command, the bitwise inverse of the sum of id through the last parameter.
  always_comb begin
    if (q_rdata.torque) begin
      cks_nxt = ~(q_rdata.id + LEN_TORQUE + OP_TORQUE + TORQUE_PARAM);
    end else begin
      cks_nxt = ~(q_rdata.id + LEN_MOVE + OP_MOVE + q_rdata.pos[7:0]
                + {{(16 - POS_W){1'b0}}, q_rdata.pos[POS_W-1:8]}
                + move_time_ms[7:0] + move_time_ms[15:8]);
    end
  end

  always_comb begin
    case (idx_r)
      BYTE_HDR0: cur_byte = HDR_BYTE;
      BYTE_HDR1: cur_byte = HDR_BYTE;
      BYTE_ID:   cur_byte = cur_r.id;
      BYTE_LEN:  cur_byte = cur_r.torque ? LEN_TORQUE : LEN_MOVE;
      BYTE_OP:   cur_byte = cur_r.torque ? OP_TORQUE : OP_MOVE;
      BYTE_P0:   cur_byte = cur_r.torque ? TORQUE_PARAM : pos_lo;
      BYTE_P1:   cur_byte = cur_r.torque ? cks_r : pos_hi;
      BYTE_P2:   cur_byte = move_time_ms[7:0];
      BYTE_P3:   cur_byte = move_time_ms[15:8];
      BYTE_CKS:  cur_byte = cks_r;
      default:   cur_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (advance) begin
        if (is_last) begin
          busy_r <= 1'b0;
          idx_r  <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_rdata;
      cks_r <= cks_nxt;
    end
    if (advance) begin
      out_data_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/servo_bus_command_framer_unit.sv
// Serial bus servo command framer.
// Input channel: one command per transfer. in_tuser is the mode (0 move to
// angle, 1 enable torque), in_tdata carries the servo id and the signed angle
// in 1/16 degree. Output channel: one frame byte per transfer, in transmit
// order, with out_tlast on the checksum byte. A move command yields ten bytes,
// a torque command seven.
// The cfg port writes the move time in milliseconds placed in every move
// frame; it resets to 100 and should be written only while no frame is pending.
// From input to output, when the block is idle, a command passes the command
// queue, the sequencer register and the output register before its first byte
// is valid. Throughput: one byte per cycle while out_tready is high; the byte
// sequencer in the back end is the limiting unit. Commands are taken while a
// frame is still going out, up to the two-entry command queue.
// Reset clears the queue, the sequencer and the output register; no result is
// valid during reset. When the receiver stalls, the current byte holds and the
// queue fills, after which in_tready drops.
module servo_bus_command_framer_unit
  import sbcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // [7:0] servo_id, [23:8] angle_q4
  input  logic        in_tuser,     // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] tx_byte
  output logic        out_tlast,    // last_byte
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data   // move_time_ms
);

  logic [15:0] move_time_r;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  cmd_t        q_wdata;
  cmd_t        q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_time_r <= MOVE_TIME_RESET;
    end else if (cfg_wr_en) begin
      move_time_r <= cfg_wr_data;
    end
  end

  sbcf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sbcf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  sbcf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .move_time_ms (move_time_r),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

FILE: rtl/core/sbcf_checker.sv
// Port-level checks for the servo bus command framer, attached by bind.
// Depends on sbcf_pkg for the header byte constant.
module sbcf_checker
  import sbcf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] bpos_r;
  logic [3:0] open_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Byte position within the current frame and the count of frames owed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpos_r <= '0;
      open_r <= '0;
    end else begin
      if (out_xfer) begin
        bpos_r <= out_tlast ? 4'd0 : bpos_r + 4'd1;
      end
      if (in_xfer && !(out_xfer && out_tlast)) begin
        open_r <= open_r + 4'd1;
      end else if (!in_xfer && out_xfer && out_tlast) begin
        open_r <= open_r - 4'd1;
      end
    end
  end

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output byte changed");

  a_header_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && (bpos_r == 4'd0 || bpos_r == 4'd1) |-> out_tdata == HDR_BYTE)
    else $error("frame does not start with two header bytes");

  a_frame_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_tlast |-> (bpos_r == 4'd6 || bpos_r == 4'd9))
    else $error("frame ended at a wrong length");

  a_no_extra_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> open_r != 4'd0)
    else $error("output byte with no command outstanding");

endmodule

bind servo_bus_command_framer_unit sbcf_checker u_sbcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
